// File: rtl/moe_pkg.sv
`default_nettype none

package moe_pkg;

   // Patch and resend limits
   localparam int PATCH_SIZE  = 128;
   localparam int RESEND_RATE = 32;

   // Job queue between front and back, power of two
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   // MIDI bytes
   localparam logic [7:0] NOTE_ON_STATUS = 8'h90;
   localparam logic [7:0] CONTROL_STATUS = 8'hB0;
   localparam logic [7:0] CC_NRPN_LSB    = 8'h62;
   localparam logic [7:0] CC_DATA_MSB    = 8'h06;
   localparam logic [7:0] CC_DATA_LSB    = 8'h26;
   localparam logic [7:0] DATA_MSB_ONE   = 8'h01;
   localparam logic [7:0] DATA_LOW_MASK  = 8'h7F;

   // Event kinds
   localparam logic [1:0] OP_NOTE_KILLED    = 2'd0;
   localparam logic [1:0] OP_NOTE_TRIGGERED = 2'd1;
   localparam logic [1:0] OP_PARAM_CHANGE   = 2'd2;

   // Output modes
   localparam logic [1:0] MODE_OTHER     = 2'd0;
   localparam logic [1:0] MODE_SEQUENCER = 2'd1;

   // CSR map
   localparam int         CSR_INDEX_W     = 2;
   localparam int         CSR_DATA_W      = 5;
   localparam logic [1:0] CSR_CHANNEL     = 2'd0;
   localparam logic [1:0] CSR_OUT_MODE    = 2'd1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] note_number;
      logic [7:0] note_velocity;
      logic [7:0] param_index;
      logic [7:0] param_value;
   } req_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       last_byte;
   } rsp_type;

   // One decoded event: up to three triples sharing one status byte.
   // The tail triple is always sent; select and MSB triples are optional.
   typedef struct packed {
      logic [7:0] status;
      logic       sel_en;
      logic       msb_en;
      logic [7:0] sel_index;
      logic [7:0] tail_a;
      logic [7:0] tail_b;
   } job_type;

   typedef struct packed {
      logic push;
      logic full;
      logic pop;
      logic empty;
   } job_ctl_type;

endpackage

`default_nettype wire

// File: rtl/moe_job_fifo.sv
`default_nettype none

module moe_job_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire moe_pkg::job_type wr_data,
   output logic                  full,
   input  wire logic             pop,
   output moe_pkg::job_type      rd_data,
   output logic                  empty
);
   import moe_pkg::*;

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_PTR_W:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (JOB_PTR_W+1)'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/moe_front.sv
`default_nettype none

module moe_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire moe_pkg::req_type                 req_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [moe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [moe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             job_full,
   output logic                                  job_push,
   output moe_pkg::job_type                      job_data
);
   import moe_pkg::*;

   logic [4:0] channel_setting_ff;
   logic [1:0] out_mode_ff;
   logic [7:0] last_index_ff, last_index_in;
   logic [7:0] resend_cnt_ff, resend_cnt_in;

   logic       accept;
   logic [4:0] setting_m1;
   logic [3:0] channel;
   logic       full_mode, seq_mode;
   logic       in_patch;
   logic [7:0] cnt_next;
   logic       need_select;

   assign csr_ready = 1'b1;
   assign req_full  = job_full;
   assign accept    = req_push && !job_full;

   assign setting_m1 = channel_setting_ff - 5'd1;
   assign channel    = (channel_setting_ff == '0) ? 4'd0 : setting_m1[3:0];
   assign full_mode  = out_mode_ff[1];
   assign seq_mode   = (out_mode_ff == MODE_SEQUENCER);
   assign in_patch   = ({1'b0, req_data.param_index} < 9'(PATCH_SIZE));
   assign cnt_next   = resend_cnt_ff + 8'd1;
   assign need_select = (last_index_ff != req_data.param_index)
                     || (cnt_next >= 8'(RESEND_RATE));

   always_comb begin
      last_index_in      = last_index_ff;
      resend_cnt_in      = resend_cnt_ff;
      job_push           = 1'b0;
      job_data.status    = CONTROL_STATUS | {4'd0, channel};
      job_data.sel_en    = 1'b0;
      job_data.msb_en    = 1'b0;
      job_data.sel_index = req_data.param_index;
      job_data.tail_a    = CC_DATA_LSB;
      job_data.tail_b    = req_data.param_value & DATA_LOW_MASK;
      case (req_data.op)
         OP_NOTE_KILLED, OP_NOTE_TRIGGERED: begin
            job_data.status = NOTE_ON_STATUS | {4'd0, channel};
            job_data.tail_a = req_data.note_number;
            job_data.tail_b = (req_data.op == OP_NOTE_TRIGGERED) ?
                              req_data.note_velocity : 8'd0;
            job_push        = accept && seq_mode;
         end
         OP_PARAM_CHANGE: begin
            if (in_patch) begin
               resend_cnt_in = cnt_next;
               if (full_mode) begin
                  job_push        = accept;
                  job_data.msb_en = req_data.param_value[7];
                  if (need_select) begin
                     job_data.sel_en = 1'b1;
                     last_index_in   = req_data.param_index;
                     resend_cnt_in   = 8'd0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_setting_ff <= '0;
         out_mode_ff        <= MODE_OTHER;
         last_index_ff      <= '0;
         resend_cnt_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_CHANNEL:  channel_setting_ff <= csr_wdata;
               CSR_OUT_MODE: out_mode_ff        <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            last_index_ff <= last_index_in;
            resend_cnt_ff <= resend_cnt_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/moe_back.sv
`default_nettype none

module moe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_empty,
   input  wire moe_pkg::job_type job_rd,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output moe_pkg::rsp_type      rsp_data
);
   import moe_pkg::*;

   typedef enum logic [1:0] {
      SLOT_SELECT,
      SLOT_MSB,
      SLOT_TAIL
   } slot_type;

   logic     have_job_ff, have_job_in;
   job_type  job_ff, job_in;
   slot_type slot_ff, slot_in;
   logic [1:0] pos_ff, pos_in;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;

   logic       advance;
   logic       is_last;
   logic [7:0] cur_byte;
   slot_type   first_slot;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign advance   = have_job_ff && (!rsp_valid_ff || rsp_pop);
   assign is_last   = (slot_ff == SLOT_TAIL) && (pos_ff == 2'd2);
   assign job_pop   = !job_empty && (!have_job_ff || (advance && is_last));

   always_comb begin
      if (job_rd.sel_en) begin
         first_slot = SLOT_SELECT;
      end else if (job_rd.msb_en) begin
         first_slot = SLOT_MSB;
      end else begin
         first_slot = SLOT_TAIL;
      end
   end

   // byte 0 of every triple is the status byte
   always_comb begin
      cur_byte = job_ff.status;
      if (pos_ff != 2'd0) begin
         unique case (slot_ff)
            SLOT_SELECT: cur_byte = (pos_ff == 2'd1) ? CC_NRPN_LSB : job_ff.sel_index;
            SLOT_MSB:    cur_byte = (pos_ff == 2'd1) ? CC_DATA_MSB : DATA_MSB_ONE;
            SLOT_TAIL:   cur_byte = (pos_ff == 2'd1) ? job_ff.tail_a : job_ff.tail_b;
            default:     cur_byte = job_ff.status;
         endcase
      end
   end

   always_comb begin
      have_job_in  = have_job_ff;
      job_in       = job_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_in.midi_byte = cur_byte;
         rsp_in.last_byte = is_last;
         rsp_valid_in     = 1'b1;
         if (pos_ff != 2'd2) begin
            pos_in = pos_ff + 2'd1;
         end else begin
            pos_in = 2'd0;
            unique case (slot_ff)
               SLOT_SELECT: slot_in = job_ff.msb_en ? SLOT_MSB : SLOT_TAIL;
               SLOT_MSB:    slot_in = SLOT_TAIL;
               default:     have_job_in = 1'b0;
            endcase
         end
      end
      if (job_pop) begin
         have_job_in = 1'b1;
         job_in      = job_rd;
         slot_in     = first_slot;
         pos_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_job_ff  <= 1'b0;
         slot_ff      <= SLOT_TAIL;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_job_ff  <= have_job_in;
         slot_ff      <= slot_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// File: rtl/midi_out_event_encoder.sv
`default_nettype none

// Channel  Ports                                  Moves
// -------  -------------------------------------  -----------------------------
// req      req_push / req_full / req_data         one event word in
// rsp      rsp_empty / rsp_pop / rsp_data         one MIDI byte word out
// csr      csr_valid / csr_ready / csr_index/wdata  channel setting, output mode
//
// Events are decoded combinationally, and those that produce bytes are queued as
// jobs (four deep); the byte sequencer sends one byte per cycle, so an event
// sends 3, 6 or 9 bytes. The front keeps taking one event per cycle until
// the job queue fills. Reset is synchronous. A stalled rsp_pop holds the
// sequencer; full tracks only the job queue.

module midi_out_event_encoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire moe_pkg::req_type                 req_data,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output moe_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [moe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [moe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import moe_pkg::*;

   job_ctl_type job_ctl;
   job_type     job_wr;
   job_type     job_rd;

   moe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_full  (job_ctl.full),
      .job_push  (job_ctl.push),
      .job_data  (job_wr)
   );

   moe_job_fifo u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_ctl.push),
      .wr_data (job_wr),
      .full    (job_ctl.full),
      .pop     (job_ctl.pop),
      .rd_data (job_rd),
      .empty   (job_ctl.empty)
   );

   moe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_ctl.empty),
      .job_rd    (job_rd),
      .job_pop   (job_ctl.pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sim/tb_midi_out_event_encoder.sv
`default_nettype none

module tb_midi_out_event_encoder;
   import moe_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] MODE_FULL       = 2'd2;
   localparam logic [1:0] MODE_FULL_ALIAS = 2'd3;
   localparam logic [1:0] OP_IGNORED      = 2'd3;
   localparam int         PREDICTED       = -1;
   localparam int         SETTLE_CYCLES   = 20;
   localparam int         LONG_HOLD       = 400;

   typedef enum logic {ROW_EVENT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [4:0]   reg_val;
      req_type      ev;
      int           typed_n;
      logic [23:0]  typed;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor copy of config and state
   logic [4:0]  chan_setting;
   logic [1:0]  out_mode_cfg;
   logic [7:0]  last_index;
   logic [7:0]  resend_count;

   rsp_type      pending_bytes[$];
   plan_row_type plan[$];
   int           mismatch_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           hold_left;

   midi_out_event_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= 20)
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
   endtask

   // bytes one event turns into, given current config; updates index/counter
   function automatic int encode_event(input req_type ev, output logic [7:0] bytes [9]);
      logic [4:0] ch_m1;
      logic [3:0] ch;
      logic [7:0] ctl;
      int n;
      ch_m1 = chan_setting - 5'd1;
      ch    = (chan_setting == 5'd0) ? 4'd0 : ch_m1[3:0];
      ctl   = CONTROL_STATUS | {4'h0, ch};
      n     = 0;
      for (int i = 0; i < 9; i++) bytes[i] = '0;
      case (ev.op)
         OP_NOTE_KILLED, OP_NOTE_TRIGGERED: begin
            if (out_mode_cfg == MODE_SEQUENCER) begin
               bytes[0] = NOTE_ON_STATUS | {4'h0, ch};
               bytes[1] = ev.note_number;
               bytes[2] = (ev.op == OP_NOTE_TRIGGERED) ? ev.note_velocity : 8'h00;
               n = 3;
            end
         end
         OP_PARAM_CHANGE: begin
            if (ev.param_index < PATCH_SIZE) begin
               resend_count = resend_count + 8'd1;
               if (out_mode_cfg == MODE_FULL || out_mode_cfg == MODE_FULL_ALIAS) begin
                  if (last_index != ev.param_index || resend_count >= RESEND_RATE) begin
                     bytes[n] = ctl; bytes[n+1] = CC_NRPN_LSB; bytes[n+2] = ev.param_index;
                     n += 3;
                     last_index   = ev.param_index;
                     resend_count = '0;
                  end
                  if (ev.param_value[7]) begin
                     bytes[n] = ctl; bytes[n+1] = CC_DATA_MSB; bytes[n+2] = DATA_MSB_ONE;
                     n += 3;
                  end
                  bytes[n] = ctl; bytes[n+1] = CC_DATA_LSB;
                  bytes[n+2] = ev.param_value & DATA_LOW_MASK;
                  n += 3;
               end
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic req_type mk_ev(input logic [1:0] op, input logic [7:0] note, vel,
                                     idx, val);
      req_type ev;
      ev.op = op;
      ev.note_number = note;
      ev.note_velocity = vel;
      ev.param_index = idx;
      ev.param_value = val;
      return ev;
   endfunction

   function automatic plan_row_type ev_row(input logic [1:0] op, input logic [7:0] note, vel,
                                           idx, val, input int n, input logic [23:0] t);
      plan_row_type r;
      r.kind = ROW_EVENT;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.ev = mk_ev(op, note, vel, idx, val);
      r.typed_n = n;
      r.typed = t;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [4:0] val);
      plan_row_type r;
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = val;
      r.ev = '0;
      r.typed_n = 0;
      r.typed = '0;
      return r;
   endfunction

   function automatic req_type random_event(input logic [1:0] mode);
      req_type ev;
      int pick;
      int ipick;
      pick  = $urandom_range(99);
      ipick = $urandom_range(99);
      ev.note_number   = 8'($urandom);
      ev.note_velocity = 8'($urandom);
      ev.param_value   = 8'($urandom);
      if (ipick < 50)
         ev.param_index = 8'($urandom_range(3));
      else if (ipick < 85)
         ev.param_index = 8'($urandom_range(PATCH_SIZE - 1));
      else
         ev.param_index = 8'($urandom_range(255, PATCH_SIZE));
      if (pick < 5)
         ev.op = OP_IGNORED;
      else if (mode == MODE_SEQUENCER)
         ev.op = (pick < 80) ? ((pick & 1) ? OP_NOTE_TRIGGERED : OP_NOTE_KILLED)
                             : OP_PARAM_CHANGE;
      else if (mode >= MODE_FULL)
         ev.op = (pick < 85) ? OP_PARAM_CHANGE
                             : ((pick & 1) ? OP_NOTE_TRIGGERED : OP_NOTE_KILLED);
      else
         ev.op = 2'($urandom_range(2));
      return ev;
   endfunction

   // hold push low until every expected word is out, then let the design settle
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [4:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CHANNEL:  chan_setting = val;
         CSR_OUT_MODE: out_mode_cfg = val[1:0];
         default: ;
      endcase
   endtask

   task automatic send_event(input req_type ev, input int typed_n, input logic [23:0] typed);
      logic [7:0] bytes [9];
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= ev;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n = encode_event(ev, bytes);
      if (typed_n != PREDICTED) begin
         n = typed_n;
         bytes[0] = typed[23:16];
         bytes[1] = typed[15:8];
         bytes[2] = typed[7:0];
      end
      for (int i = 0; i < n; i++)
         pending_bytes.push_back('{midi_byte: bytes[i], last_byte: (i == n - 1)});
   endtask

   task automatic run_phase(input logic [4:0] chan, input logic [1:0] mode, input int count,
                            input int send_pct, input int recv_pct, input bit hold,
                            input bit pause);
      write_csr(CSR_CHANNEL, chan);
      write_csr(CSR_OUT_MODE, {3'b000, mode});
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold) hold_left = LONG_HOLD;
      for (int i = 0; i < count; i++) begin
         if (pause && i == count / 2) wait_drained();
         send_event(random_event(mode), PREDICTED, '0);
      end
   endtask

   // receiver: checks each popped word against the oldest expected one
   initial begin
      rsp_type want;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && rsp_empty === 1'b0) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.midi_byte, 8'h00);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_data.midi_byte !== want.midi_byte)
                  report_mismatch("midi_byte", rsp_data.midi_byte, want.midi_byte);
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch("last_byte", 8'(rsp_data.last_byte), 8'(want.last_byte));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int n_params;
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      chan_setting = '0;
      out_mode_cfg = MODE_OTHER;
      last_index = '0;
      resend_count = '0;
      mismatch_count = 0;
      send_idle_pct = 10;
      recv_idle_pct = 62;
      hold_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part; reset config is channel 0, other mode
      plan.push_back(ev_row(OP_NOTE_TRIGGERED, 8'h3C, 8'h64, 8'h00, 8'h00, 0, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h05, 8'h10, 0, '0));
      plan.push_back(csr_row(CSR_OUT_MODE, {3'b000, MODE_SEQUENCER}));
      plan.push_back(ev_row(OP_NOTE_TRIGGERED, 8'hFF, 8'hFF, 8'h00, 8'h00, 3, 24'h90FFFF));
      plan.push_back(ev_row(OP_NOTE_KILLED, 8'h00, 8'hFF, 8'h00, 8'h00, 3, 24'h900000));
      plan.push_back(ev_row(OP_IGNORED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h7F, 8'hFF, 0, '0));
      plan.push_back(csr_row(CSR_CHANNEL, 5'd1));
      plan.push_back(ev_row(OP_NOTE_TRIGGERED, 8'h00, 8'h00, 8'h00, 8'h00, 3, 24'h900000));
      plan.push_back(csr_row(CSR_CHANNEL, 5'd16));
      plan.push_back(ev_row(OP_NOTE_TRIGGERED, 8'h7F, 8'h01, 8'h00, 8'h00, 3, 24'h9F7F01));
      // channel setting past 16 wraps into the low nibble
      plan.push_back(csr_row(CSR_CHANNEL, 5'd31));
      plan.push_back(ev_row(OP_NOTE_KILLED, 8'h80, 8'h55, 8'h00, 8'h00, 3, 24'h9E8000));
      plan.push_back(csr_row(CSR_CHANNEL, 5'd2));
      plan.push_back(csr_row(CSR_OUT_MODE, {3'b000, MODE_FULL}));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h00, 8'h00, 3, 24'hB12600));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h7F, 8'hFF, PREDICTED, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'hFF, 8'hFF, 8'h80, 8'h00, 0, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'hFF, 8'hFF, 8'hFF, 8'h80, 0, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h7F, 8'h7F, 3, 24'hB1267F));
      plan.push_back(ev_row(OP_NOTE_TRIGGERED, 8'h40, 8'h40, 8'h00, 8'h00, 0, '0));
      plan.push_back(ev_row(OP_NOTE_KILLED, 8'h40, 8'h40, 8'h00, 8'h00, 0, '0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h7F, 8'h80, PREDICTED, '0));
      plan.push_back(csr_row(CSR_OUT_MODE, {3'b000, MODE_FULL_ALIAS}));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h01, 8'h01, PREDICTED, '0));
      plan.push_back(ev_row(OP_IGNORED, 8'h00, 8'h00, 8'h00, 8'h00, 0, '0));
      plan.push_back(csr_row(CSR_CHANNEL, 5'd0));
      plan.push_back(ev_row(OP_PARAM_CHANGE, 8'h00, 8'h00, 8'h01, 8'hAA, PREDICTED, '0));
      plan.push_back(csr_row(CSR_OUT_MODE, {3'b000, MODE_OTHER}));
      plan.push_back(ev_row(OP_NOTE_KILLED, 8'h12, 8'h34, 8'h00, 8'h00, 0, '0));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_csr(plan[i].reg_idx, plan[i].reg_val);
         else
            send_event(plan[i].ev, plan[i].typed_n, plan[i].typed);
      end

      run_phase(5'd5, MODE_FULL, 16, 10, 62, 1'b0, 1'b0);
      run_phase(5'd16, MODE_SEQUENCER, 16, 10, 62, 1'b0, 1'b0);
      // long receiver stall while full-mode events keep coming: job queue fills
      run_phase(5'd31, MODE_FULL_ALIAS, 16, 62, 10, 1'b1, 1'b0);
      run_phase(5'd0, MODE_FULL, 16, 62, 10, 1'b0, 1'b1);

      // counter wrap: enough parameter words outside full mode to carry the
      // counter once past 255 and land it at 2, then repeat the stored index
      // in full mode
      write_csr(CSR_CHANNEL, 5'd7);
      write_csr(CSR_OUT_MODE, {3'b000, MODE_SEQUENCER});
      send_idle_pct = 0;
      recv_idle_pct = 0;
      n_params = 256 + 2 - int'(resend_count);
      for (int i = 0; i < n_params; i++) begin
         if (i % 16 == 0)
            send_event(mk_ev(OP_NOTE_TRIGGERED, 8'($urandom), 8'($urandom), 8'h00, 8'h00),
                       PREDICTED, '0);
         send_event(mk_ev(OP_PARAM_CHANGE, 8'($urandom), 8'($urandom),
                          8'($urandom_range(PATCH_SIZE - 1)), 8'($urandom)), PREDICTED, '0);
      end
      write_csr(CSR_OUT_MODE, {3'b000, MODE_FULL});
      send_event(mk_ev(OP_PARAM_CHANGE, 8'h00, 8'h00, last_index, 8'($urandom)),
                 PREDICTED, '0);

      run_phase(5'($urandom_range(31)), 2'($urandom_range(3)), 16, 0, 0, 1'b0, 1'b0);
      run_phase(5'd9, MODE_FULL, 16, 0, 0, 1'b0, 1'b0);

      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
